// ===== design/path_distance_clipper_macros.svh =====
// Assertion helpers shared by the clipper modules.
`ifndef PATH_DISTANCE_CLIPPER_MACROS_SVH
`define PATH_DISTANCE_CLIPPER_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define PDC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define PDC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/pdc_pkg.sv =====
`default_nettype none

package pdc_pkg;

	// coordinate format
	localparam int COORD_BITS = 24;
	// difference magnitudes at or above 2^WIDE_SHIFT are halved before squaring
	localparam int WIDE_SHIFT = 31;
	localparam int OP_BITS    = (COORD_BITS > WIDE_SHIFT) ? WIDE_SHIFT : COORD_BITS;
	localparam int SQ_BITS    = 2 * OP_BITS + 1;
	localparam int ROOT_BITS  = (SQ_BITS + 1) / 2;
	localparam int RAD_BITS   = 2 * ROOT_BITS;
	localparam int REM_BITS   = ROOT_BITS + 2;
	localparam int CNT_BITS   = $clog2(ROOT_BITS);
	localparam int D_BITS     = ROOT_BITS + 1;
	localparam int ACC_BITS   = 32;
	localparam int SUM_BITS   = ((D_BITS > ACC_BITS) ? D_BITS : ACC_BITS) + 1;

	// configuration registers
	localparam int MAXD_BITS    = 24;
	localparam int NEAR_BITS    = 16;
	localparam int ADDR_BITS    = 3;
	localparam int DATA_BITS    = 32;
	localparam int REG_IDX_BITS = 1;
	localparam logic [REG_IDX_BITS-1:0] REG_MAX_DIST = 1'b0;
	localparam logic [REG_IDX_BITS-1:0] REG_NEAR     = 1'b1;
	localparam logic [MAXD_BITS-1:0] MAXD_RESET = 24'd131072;
	localparam logic [NEAR_BITS-1:0] NEAR_RESET = 16'd3932;

	// passed-point count
	localparam logic [1:0] PASS_NONE  = 2'd0;
	localparam logic [1:0] PASS_FIRST = 2'd1;
	localparam logic [1:0] PASS_MAX   = 2'd3;

	typedef struct packed {
		logic load;
		logic sq_first;
		logic sq_second;
		logic commit;
	} pdc_cmd_t;

	typedef struct packed {
		logic bypass;
		logic root_busy;
		logic root_last;
		logic out_free;
	} pdc_stat_t;

endpackage

`default_nettype wire

// ===== design/pdc_sqrt.sv =====
`default_nettype none

module pdc_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pdc_pkg::SQ_BITS-1:0]   rad,
	output logic [pdc_pkg::ROOT_BITS-1:0] root,
	output logic                          busy,
	output logic                          last_step
);
	import pdc_pkg::*;

	logic                 busy_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic [RAD_BITS-1:0]  rad_q;
	logic [REM_BITS-1:0]  rem_q;
	logic [ROOT_BITS-1:0] root_q;
	logic [REM_BITS+1:0]  shifted;
	logic [REM_BITS+1:0]  trial;
	logic                 fits;

	// one result bit per cycle, restoring
	assign shifted = {rem_q, rad_q[RAD_BITS-1 -: 2]};
	assign trial   = (REM_BITS + 2)'({root_q, 2'b01});
	assign fits    = shifted >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_BITS'(ROOT_BITS - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= RAD_BITS'(rad);
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[RAD_BITS-3:0], 2'b00};
			if (fits) begin
				rem_q  <= REM_BITS'(shifted - trial);
				root_q <= {root_q[ROOT_BITS-2:0], 1'b1};
			end else begin
				rem_q  <= REM_BITS'(shifted);
				root_q <= {root_q[ROOT_BITS-2:0], 1'b0};
			end
		end
	end

	assign root      = root_q;
	assign busy      = busy_q;
	assign last_step = busy_q && (cnt_q == '0);

endmodule

`default_nettype wire

// ===== design/pdc_dp.sv =====
`default_nettype none
`include "path_distance_clipper_macros.svh"

module pdc_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pdc_pkg::pdc_cmd_t                    cmd,
	output pdc_pkg::pdc_stat_t                   stat,
	input  logic signed [pdc_pkg::COORD_BITS-1:0] x_coord,
	input  logic signed [pdc_pkg::COORD_BITS-1:0] y_coord,
	input  logic                                 last_point,
	input  logic [pdc_pkg::MAXD_BITS-1:0]        length_limit,
	input  logic [pdc_pkg::NEAR_BITS-1:0]        near_radius,
	input  logic                                 out_stall,
	output logic                                 out_valid,
	output logic signed [pdc_pkg::COORD_BITS-1:0] x_out,
	output logic signed [pdc_pkg::COORD_BITS-1:0] y_out,
	output logic                                 last_out
);
	import pdc_pkg::*;

	logic signed [COORD_BITS-1:0] x_q, y_q, prev_x_q, prev_y_q;
	logic                         last_q;
	logic [ACC_BITS-1:0]          sum_q;
	logic [1:0]                   count_q;
	logic                         clip_q;
	logic                         at_start_q;
	logic                         out_valid_q;
	logic signed [COORD_BITS-1:0] x_out_q, y_out_q;
	logic                         last_out_q;
	logic [SQ_BITS-1:0]           sq_q;

	logic signed [COORD_BITS:0] dx_s, dy_s;
	logic [COORD_BITS-1:0]      dx_mag, dy_mag;
	logic                       wide;
	logic [OP_BITS-1:0]         dx_op, dy_op, mul_a;
	logic [2*OP_BITS-1:0]       prod;
	logic [SQ_BITS-1:0]         rad;
	logic [ROOT_BITS-1:0]       root;
	logic                       root_busy, root_last;
	logic [D_BITS-1:0]          seg;
	logic                       near_hit;
	logic [SUM_BITS-1:0]        sum_ext;
	logic [ACC_BITS-1:0]        sum_sat;
	logic [1:0]                 count_inc;
	logic                       clip_hit;
	logic                       emit;
	logic                       final_pt;

	// segment from the last passed point; with one point passed it is the start point
	assign dx_s   = {x_q[COORD_BITS-1], x_q} - {prev_x_q[COORD_BITS-1], prev_x_q};
	assign dy_s   = {y_q[COORD_BITS-1], y_q} - {prev_y_q[COORD_BITS-1], prev_y_q};
	assign dx_mag = dx_s[COORD_BITS] ? COORD_BITS'(-dx_s) : dx_s[COORD_BITS-1:0];
	assign dy_mag = dy_s[COORD_BITS] ? COORD_BITS'(-dy_s) : dy_s[COORD_BITS-1:0];
	assign wide   = ((dx_mag >> WIDE_SHIFT) != '0) || ((dy_mag >> WIDE_SHIFT) != '0);
	assign dx_op  = wide ? OP_BITS'(dx_mag >> 1) : OP_BITS'(dx_mag);
	assign dy_op  = wide ? OP_BITS'(dy_mag >> 1) : OP_BITS'(dy_mag);

	// one shared squarer: dx on the first pass, dy on the second
	assign mul_a = cmd.sq_first ? dx_op : dy_op;
	assign prod  = mul_a * mul_a;
	assign rad   = sq_q + SQ_BITS'(prod);

	pdc_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.sq_second),
		.rad       (rad),
		.root      (root),
		.busy      (root_busy),
		.last_step (root_last)
	);

	assign seg       = wide ? {root, 1'b0} : {1'b0, root};
	assign near_hit  = (count_q == PASS_FIRST) && !last_q && (seg < D_BITS'(near_radius));
	assign sum_ext   = SUM_BITS'(sum_q) + SUM_BITS'(seg);
	assign sum_sat   = ((sum_ext >> ACC_BITS) != '0) ? '1 : ACC_BITS'(sum_ext);
	assign count_inc = (count_q == PASS_MAX) ? count_q : count_q + 2'd1;
	assign clip_hit  = (sum_sat >= ACC_BITS'(length_limit)) && (count_inc == PASS_MAX);
	assign emit      = at_start_q || (!clip_q && !near_hit);
	assign final_pt  = at_start_q ? last_q : (last_q || clip_hit);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q    <= x_coord;
			y_q    <= y_coord;
			last_q <= last_point;
		end
		if (cmd.sq_first) begin
			sq_q <= SQ_BITS'(prod);
		end
		if (cmd.commit && emit) begin
			x_out_q    <= x_q;
			y_out_q    <= y_q;
			last_out_q <= final_pt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			sum_q       <= '0;
			count_q     <= PASS_NONE;
			clip_q      <= 1'b0;
			at_start_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit && emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.commit) begin
				priority if (at_start_q) begin
					prev_x_q   <= x_q;
					prev_y_q   <= y_q;
					sum_q      <= '0;
					count_q    <= PASS_FIRST;
					clip_q     <= 1'b0;
					at_start_q <= last_q;
				end else if (clip_q) begin
					if (last_q) begin
						clip_q     <= 1'b0;
						at_start_q <= 1'b1;
					end
				end else if (!near_hit) begin
					prev_x_q   <= x_q;
					prev_y_q   <= y_q;
					sum_q      <= sum_sat;
					count_q    <= count_inc;
					clip_q     <= clip_hit && !last_q;
					at_start_q <= last_q;
				end
			end
		end
	end

	assign stat.bypass    = at_start_q || clip_q;
	assign stat.root_busy = root_busy;
	assign stat.root_last = root_last;
	assign stat.out_free  = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign x_out     = x_out_q;
	assign y_out     = y_out_q;
	assign last_out  = last_out_q;

	`PDC_ASSERT_IMP(a_count_set, clk, arst_n, !at_start_q, count_q != PASS_NONE, "path open with no point passed")
	`PDC_ASSERT_IMP(a_clip_full, clk, arst_n, clip_q, (count_q == PASS_MAX) && !at_start_q, "clip without three points")
	`PDC_ASSERT_IMP(a_out_rise, clk, arst_n, $rose(out_valid_q), $past(cmd.commit), "result without commit")

endmodule

`default_nettype wire

// ===== design/pdc_ctrl.sv =====
`default_nettype none
`include "path_distance_clipper_macros.svh"

module pdc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  pdc_pkg::pdc_stat_t stat,
	output pdc_pkg::pdc_cmd_t  cmd
);
	import pdc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQ1,
		ST_SQ2,
		ST_ROOT,
		ST_DONE
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_SQ1;
				ST_SQ1:  state_q <= stat.bypass ? ST_DONE : ST_SQ2;
				ST_SQ2:  state_q <= ST_ROOT;
				ST_ROOT: if (stat.root_last) state_q <= ST_DONE;
				ST_DONE: if (stat.out_free) state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.load      = (state_q == ST_IDLE) && in_valid;
		cmd.sq_first  = (state_q == ST_SQ1);
		cmd.sq_second = (state_q == ST_SQ2);
		cmd.commit    = (state_q == ST_DONE) && stat.out_free;
	end

	assign in_stall = (state_q != ST_IDLE);

	`PDC_ASSERT_NXT(a_root_start, clk, arst_n, cmd.sq_second, stat.root_busy, "root unit did not start")
	`PDC_ASSERT_IMP(a_commit_free, clk, arst_n, cmd.commit, stat.out_free, "commit into a full output")

endmodule

`default_nettype wire

// ===== design/path_distance_clipper.sv =====
// Path length clipper. Waypoints come in one item at a time as signed x/y
// positions with 16 fraction bits plus a final-point flag; each item gives
// zero or one result item with the same coordinates and a final flag. The
// first point of a path is always passed. While it is the only point passed,
// later points inside near_radius of it are dropped unless they are final.
// The Euclidean length of every passed segment, floor(sqrt(dx^2 + dy^2)), is
// added to a saturating 32-bit sum; once the sum reaches length_limit with at
// least three points passed, that point leaves marked final and the rest of
// the path is dropped up to and including its final waypoint. Timing: an item
// that needs a segment length goes from its accept through the squaring of
// dx and then dy on a single shared squarer and the square-root unit, which
// resolves one result bit per cycle, to its commit before the next accept;
// the first point of a path and items dropped after a clip skip the dy square
// and the root. A finished result waits in the output register while the next
// item is taken. There is no clearing pass after reset. Registers sit on the APB
// port: length_limit at byte 0 (24 bits, reset 2.0 m), near_radius at byte 4
// (16 bits, reset 0.06 m); write them only while the block is idle.
`default_nettype none

module path_distance_clipper (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// waypoint items in
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [pdc_pkg::COORD_BITS-1:0] x_coord,
	input  logic signed [pdc_pkg::COORD_BITS-1:0] y_coord,
	input  logic                                  last_point,
	// clipped path items out
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [pdc_pkg::COORD_BITS-1:0] x_out,
	output logic signed [pdc_pkg::COORD_BITS-1:0] y_out,
	output logic                                  last_out,
	// configuration
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [pdc_pkg::ADDR_BITS-1:0]         paddr,
	input  logic [pdc_pkg::DATA_BITS-1:0]         pwdata,
	output logic [pdc_pkg::DATA_BITS-1:0]         prdata,
	output logic                                  pready
);
	import pdc_pkg::*;

	logic [MAXD_BITS-1:0]    max_q;
	logic [NEAR_BITS-1:0]    near_q;
	logic [REG_IDX_BITS-1:0] reg_idx;
	pdc_cmd_t                cmd;
	pdc_stat_t               stat;

	// Registers are word spaced; decode on the word index only.
	assign reg_idx = paddr[ADDR_BITS-1:2];
	assign pready  = 1'b1;

	// Write on the access phase of the transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q  <= MAXD_RESET;
			near_q <= NEAR_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				REG_MAX_DIST: max_q  <= MAXD_BITS'(pwdata);
				REG_NEAR:     near_q <= NEAR_BITS'(pwdata);
			endcase
		end
	end

	// Read back the register selected by the address.
	always_comb begin
		unique case (reg_idx)
			REG_MAX_DIST: prdata = DATA_BITS'(max_q);
			REG_NEAR:     prdata = DATA_BITS'(near_q);
		endcase
	end

	// Sequencer: accept, square dx, square dy and start the root, iterate, commit.
	pdc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Item registers, squarer, root unit, path state and output register.
	pdc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.x_coord      (x_coord),
		.y_coord      (y_coord),
		.last_point   (last_point),
		.length_limit (max_q),
		.near_radius  (near_q),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.x_out        (x_out),
		.y_out        (y_out),
		.last_out     (last_out)
	);

endmodule

`default_nettype wire
